// File: design/dtq_pkg.sv
package dtq_pkg;

    localparam int DL_W     = 48;
    localparam int HANDLE_W = 8;
    localparam int TMO_W    = 32;
    localparam int ENTRY_W  = DL_W + HANDLE_W + 1;

    typedef logic [2:0] status_t;
    typedef logic [1:0] kind_t;

    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_FULL     = 3'd1;
    localparam status_t ST_EXPIRED  = 3'd2;
    localparam status_t ST_NONE     = 3'd3;
    localparam status_t ST_NO_TIMER = 3'd4;

    localparam kind_t KIND_ADD    = 2'd0;
    localparam kind_t KIND_CANCEL = 2'd1;
    localparam kind_t KIND_EXPIRE = 2'd2;
    localparam kind_t KIND_UNUSED = 2'd3;

endpackage

// File: design/dtq_ram.sv
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/deadline_timer_queue.sv
// Timer queue ordered by deadline. An add beat stores deadline = now_ms + timeout_ms
// (saturating at 2^48-1) in the lowest free slot, links the handle to it and sifts it up
// a binary min-heap; a full queue answers status 1 and changes nothing. A cancel beat
// marks the handle's linked timer deleted (status 0) or answers status 4. An expire beat
// pops the earliest timers while they are due (deadline <= now_ms), silently drops deleted
// ones, and gives one status 2 beat per notifying timer, or one status 3 beat if none;
// the final beat of every input carries last. Ties go to the lower slot. One input beat is
// worked at a time; the heap order, the timer entries and the handle links sit in three
// single-port-read RAMs with registered reads, so each heap level costs a chain of reads.
// A new beat is taken when the engine is idle, even while the last result still waits on
// out_stall. No clearing pass is needed after reset.
module deadline_timer_queue #(
    parameter int TIMER_SLOTS  = 64,
    parameter int HANDLE_COUNT = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      kind,
    input  logic [dtq_pkg::HANDLE_W-1:0]    handle,
    input  logic [dtq_pkg::TMO_W-1:0]       timeout_ms,
    input  logic                            notify,
    input  logic [dtq_pkg::DL_W-1:0]        now_ms,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      status,
    output logic [dtq_pkg::HANDLE_W-1:0]    expired_handle,
    output logic                            last
);

    import dtq_pkg::*;

    localparam int SW = $clog2(TIMER_SLOTS);
    localparam int CW = $clog2(TIMER_SLOTS + 1);
    localparam int PW = SW + 2;
    localparam int KW = DL_W + SW;
    localparam int LINK_DEPTH = (HANDLE_COUNT < 256) ? HANDLE_COUNT : 256;
    localparam int LAW = $clog2(LINK_DEPTH);

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_ADD    = 5'd1;
    localparam logic [4:0] S_UP     = 5'd2;
    localparam logic [4:0] S_UP_H   = 5'd3;
    localparam logic [4:0] S_UP_E   = 5'd4;
    localparam logic [4:0] S_CAN    = 5'd5;
    localparam logic [4:0] S_CAN_L  = 5'd6;
    localparam logic [4:0] S_EXP    = 5'd7;
    localparam logic [4:0] S_EXP_H  = 5'd8;
    localparam logic [4:0] S_EXP_E  = 5'd9;
    localparam logic [4:0] S_POP_LC = 5'd10;
    localparam logic [4:0] S_POP_M  = 5'd11;
    localparam logic [4:0] S_POP_MH = 5'd12;
    localparam logic [4:0] S_POP_ME = 5'd13;
    localparam logic [4:0] S_DN     = 5'd14;
    localparam logic [4:0] S_DN_LH  = 5'd15;
    localparam logic [4:0] S_DN_LE  = 5'd16;
    localparam logic [4:0] S_DN_RH  = 5'd17;
    localparam logic [4:0] S_DN_RE  = 5'd18;
    localparam logic [4:0] S_DN_C   = 5'd19;
    localparam logic [4:0] S_EMIT   = 5'd20;

    logic [4:0] state_reg, state_next;

    // latched input beat
    logic [HANDLE_W-1:0] handle_reg;
    logic [TMO_W-1:0]    timeout_reg;
    logic                notify_reg;
    logic [DL_W-1:0]     now_reg;

    // queue bookkeeping in flops
    logic [CW-1:0]          count_reg, count_next;
    logic [TIMER_SLOTS-1:0] free_reg, free_next;
    logic [TIMER_SLOTS-1:0] del_reg, del_next;
    logic [LINK_DEPTH-1:0]  lvalid_reg, lvalid_next;

    // sift working registers: moving element, candidate child, other child
    logic [SW-1:0]       pos_reg, pos_next;
    logic [SW-1:0]       mv_slot_reg, mv_slot_next;
    logic [KW-1:0]       mv_key_reg, mv_key_next;
    logic [SW-1:0]       cand_slot_reg, cand_slot_next;
    logic [SW-1:0]       cand_pos_reg, cand_pos_next;
    logic [KW-1:0]       cand_key_reg, cand_key_next;
    logic [SW-1:0]       oth_slot_reg, oth_slot_next;
    logic [SW-1:0]       root_slot_reg, root_slot_next;
    logic [HANDLE_W-1:0] rh_reg, rh_next;
    logic                report_reg, report_next;

    // pending result: the last one is only known once the sweep ends
    logic [2:0]          res_status_reg, res_status_next;
    logic [HANDLE_W-1:0] res_handle_reg, res_handle_next;
    logic                pend_reg, pend_next;

    // output register
    logic                out_valid_reg;
    logic [2:0]          status_reg;
    logic [HANDLE_W-1:0] exp_handle_reg;
    logic                last_reg;
    logic                out_free, out_load, out_last_d;
    logic [2:0]          out_status_d;
    logic [HANDLE_W-1:0] out_handle_d;

    // memory ports
    logic               heap_we;
    logic [SW-1:0]      heap_waddr, heap_wdata, heap_raddr, heap_rdata;
    logic               ent_we;
    logic [SW-1:0]      ent_waddr, ent_raddr;
    logic [ENTRY_W-1:0] ent_wdata, ent_rdata;
    logic               link_we;
    logic [LAW-1:0]     link_waddr, link_raddr;
    logic [SW-1:0]      link_wdata, link_rdata;

    logic               in_accept;
    logic [DL_W:0]      dl_sum;
    logic [DL_W-1:0]    dl_sat;
    logic [SW-1:0]      free_slot;
    logic               handle_ok, rh_ok;
    logic [PW-1:0]      l_pos, r_pos, cnt_ext;
    logic [SW-1:0]      parent_pos;
    logic [KW-1:0]      ent_key_cand, ent_key_oth;
    logic [HANDLE_W-1:0] ent_handle;

    dtq_ram #(.WIDTH(SW), .DEPTH(TIMER_SLOTS)) u_heap (
        .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
        .raddr(heap_raddr), .rdata(heap_rdata)
    );

    dtq_ram #(.WIDTH(ENTRY_W), .DEPTH(TIMER_SLOTS)) u_entry (
        .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(ent_raddr), .rdata(ent_rdata)
    );

    dtq_ram #(.WIDTH(SW), .DEPTH(LINK_DEPTH)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign expired_handle = exp_handle_reg;
    assign last           = last_reg;

    // saturating deadline
    assign dl_sum = {1'b0, now_reg} + {{(DL_W + 1 - TMO_W){1'b0}}, timeout_reg};
    assign dl_sat = dl_sum[DL_W] ? {DL_W{1'b1}} : dl_sum[DL_W-1:0];

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (free_reg[i])
            begin
                free_slot = SW'(i);
            end
        end
    end

    assign ent_handle = ent_rdata[DL_W +: HANDLE_W];
    assign handle_ok  = (13'(handle_reg) < 13'(HANDLE_COUNT));
    assign rh_ok      = (13'(rh_reg) < 13'(HANDLE_COUNT));
    assign l_pos      = PW'({pos_reg, 1'b1});
    assign r_pos      = l_pos + PW'(1);
    assign cnt_ext    = PW'(count_reg);
    assign parent_pos = (pos_reg - SW'(1)) >> 1;
    assign ent_key_cand = {ent_rdata[DL_W-1:0], cand_slot_reg};
    assign ent_key_oth  = {ent_rdata[DL_W-1:0], oth_slot_reg};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        free_next       = free_reg;
        del_next        = del_reg;
        lvalid_next     = lvalid_reg;
        pos_next        = pos_reg;
        mv_slot_next    = mv_slot_reg;
        mv_key_next     = mv_key_reg;
        cand_slot_next  = cand_slot_reg;
        cand_pos_next   = cand_pos_reg;
        cand_key_next   = cand_key_reg;
        oth_slot_next   = oth_slot_reg;
        root_slot_next  = root_slot_reg;
        rh_next         = rh_reg;
        report_next     = report_reg;
        res_status_next = res_status_reg;
        res_handle_next = res_handle_reg;
        pend_next       = pend_reg;

        out_load     = 1'b0;
        out_status_d = res_status_reg;
        out_handle_d = res_handle_reg;
        out_last_d   = 1'b1;

        heap_we    = 1'b0;
        heap_waddr = pos_reg;
        heap_wdata = mv_slot_reg;
        heap_raddr = '0;
        ent_we     = 1'b0;
        ent_waddr  = free_slot;
        ent_wdata  = {notify_reg, handle_reg, dl_sat};
        ent_raddr  = heap_rdata;
        link_we    = 1'b0;
        link_waddr = handle_reg[LAW-1:0];
        link_wdata = free_slot;
        link_raddr = rh_reg[LAW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_handle_next = '0;
                    pend_next       = 1'b0;
                    res_status_next = ST_NONE;
                    unique case (kind)
                        KIND_ADD:    state_next = S_ADD;
                        KIND_CANCEL: state_next = S_CAN;
                        KIND_EXPIRE: state_next = S_EXP;
                        KIND_UNUSED: state_next = S_IDLE;
                    endcase
                end
            end

            S_ADD:
            begin
                if (count_reg >= CW'(TIMER_SLOTS))
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_EMIT;
                end
                else
                begin
                    ent_we                = 1'b1;
                    free_next[free_slot]  = 1'b0;
                    del_next[free_slot]   = 1'b0;
                    if (handle_ok)
                    begin
                        link_we                             = 1'b1;
                        lvalid_next[handle_reg[LAW-1:0]]    = 1'b1;
                    end
                    pos_next     = count_reg[SW-1:0];
                    count_next   = count_reg + CW'(1);
                    mv_slot_next = free_slot;
                    mv_key_next  = {dl_sat, free_slot};
                    state_next   = S_UP;
                end
            end

            S_UP:
            begin
                if (pos_reg == '0)
                begin
                    heap_we         = 1'b1;
                    res_status_next = ST_OK;
                    state_next      = S_EMIT;
                end
                else
                begin
                    heap_raddr = parent_pos;
                    state_next = S_UP_H;
                end
            end

            S_UP_H:
            begin
                cand_slot_next = heap_rdata;
                ent_raddr      = heap_rdata;
                state_next     = S_UP_E;
            end

            S_UP_E:
            begin
                heap_we = 1'b1;
                if (mv_key_reg < ent_key_cand)
                begin
                    heap_wdata = cand_slot_reg;
                    pos_next   = parent_pos;
                    state_next = S_UP;
                end
                else
                begin
                    res_status_next = ST_OK;
                    state_next      = S_EMIT;
                end
            end

            S_CAN:
            begin
                link_raddr = handle_reg[LAW-1:0];
                if (handle_ok && lvalid_reg[handle_reg[LAW-1:0]])
                begin
                    state_next = S_CAN_L;
                end
                else
                begin
                    res_status_next = ST_NO_TIMER;
                    state_next      = S_EMIT;
                end
            end

            S_CAN_L:
            begin
                del_next[link_rdata] = 1'b1;
                res_status_next      = ST_OK;
                state_next           = S_EMIT;
            end

            S_EXP:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    heap_raddr = '0;
                    state_next = S_EXP_H;
                end
            end

            S_EXP_H:
            begin
                root_slot_next = heap_rdata;
                ent_raddr      = heap_rdata;
                state_next     = S_EXP_E;
            end

            S_EXP_E:
            begin
                ent_raddr  = root_slot_reg;
                link_raddr = ent_handle[LAW-1:0];
                if (!del_reg[root_slot_reg] && (ent_rdata[DL_W-1:0] > now_reg))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    report_next              = !del_reg[root_slot_reg] && ent_rdata[ENTRY_W-1];
                    rh_next                  = ent_handle;
                    count_next               = count_reg - CW'(1);
                    free_next[root_slot_reg] = 1'b1;
                    state_next               = S_POP_LC;
                end
            end

            S_POP_LC:
            begin
                if (!(report_reg && pend_reg && !out_free))
                begin
                    if (rh_ok && lvalid_reg[rh_reg[LAW-1:0]] && (link_rdata == root_slot_reg))
                    begin
                        lvalid_next[rh_reg[LAW-1:0]] = 1'b0;
                    end
                    if (report_reg)
                    begin
                        if (pend_reg)
                        begin
                            out_load     = 1'b1;
                            out_last_d   = 1'b0;
                        end
                        res_status_next = ST_EXPIRED;
                        res_handle_next = rh_reg;
                        pend_next       = 1'b1;
                    end
                    state_next = S_POP_M;
                end
            end

            S_POP_M:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_EXP;
                end
                else
                begin
                    heap_raddr = count_reg[SW-1:0];
                    state_next = S_POP_MH;
                end
            end

            S_POP_MH:
            begin
                mv_slot_next = heap_rdata;
                ent_raddr    = heap_rdata;
                state_next   = S_POP_ME;
            end

            S_POP_ME:
            begin
                mv_key_next = {ent_rdata[DL_W-1:0], mv_slot_reg};
                pos_next    = '0;
                state_next  = S_DN;
            end

            S_DN:
            begin
                if (l_pos >= cnt_ext)
                begin
                    heap_we    = 1'b1;
                    state_next = S_EXP;
                end
                else
                begin
                    heap_raddr    = l_pos[SW-1:0];
                    cand_pos_next = l_pos[SW-1:0];
                    state_next    = S_DN_LH;
                end
            end

            S_DN_LH:
            begin
                cand_slot_next = heap_rdata;
                ent_raddr      = heap_rdata;
                state_next     = S_DN_LE;
            end

            S_DN_LE:
            begin
                cand_key_next = ent_key_cand;
                if (r_pos < cnt_ext)
                begin
                    heap_raddr = r_pos[SW-1:0];
                    state_next = S_DN_RH;
                end
                else
                begin
                    state_next = S_DN_C;
                end
            end

            S_DN_RH:
            begin
                oth_slot_next = heap_rdata;
                ent_raddr     = heap_rdata;
                state_next    = S_DN_RE;
            end

            S_DN_RE:
            begin
                if (ent_key_oth < cand_key_reg)
                begin
                    cand_key_next  = ent_key_oth;
                    cand_slot_next = oth_slot_reg;
                    cand_pos_next  = r_pos[SW-1:0];
                end
                state_next = S_DN_C;
            end

            S_DN_C:
            begin
                heap_we = 1'b1;
                if (cand_key_reg < mv_key_reg)
                begin
                    heap_wdata = cand_slot_reg;
                    pos_next   = cand_pos_reg;
                    state_next = S_DN;
                end
                else
                begin
                    state_next = S_EXP;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            free_reg      <= '1;
            del_reg       <= '0;
            lvalid_reg    <= '0;
            pend_reg      <= 1'b0;
            report_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            free_reg   <= free_next;
            del_reg    <= del_next;
            lvalid_reg <= lvalid_next;
            pend_reg   <= pend_next;
            report_reg <= report_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            handle_reg  <= handle;
            timeout_reg <= timeout_ms;
            notify_reg  <= notify;
            now_reg     <= now_ms;
        end
        pos_reg         <= pos_next;
        mv_slot_reg     <= mv_slot_next;
        mv_key_reg      <= mv_key_next;
        cand_slot_reg   <= cand_slot_next;
        cand_pos_reg    <= cand_pos_next;
        cand_key_reg    <= cand_key_next;
        oth_slot_reg    <= oth_slot_next;
        root_slot_reg   <= root_slot_next;
        rh_reg          <= rh_next;
        res_status_reg  <= res_status_next;
        res_handle_reg  <= res_handle_next;
        if (out_load)
        begin
            status_reg     <= out_status_d;
            exp_handle_reg <= out_handle_d;
            last_reg       <= out_last_d;
        end
    end

endmodule

// File: design/dtq_checker.sv
module dtq_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [1:0]                   kind,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [2:0]                   status,
    input logic [dtq_pkg::HANDLE_W-1:0] expired_handle,
    input logic                         last
);

    import dtq_pkg::*;

    // an accepted add, cancel or sweep makes the engine busy, so no second beat is taken right behind it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind != KIND_UNUSED) |=> in_stall)
        else $error("engine took a second beat right after a real command");

    // only expiry beats carry a handle
    a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_EXPIRED) |-> (expired_handle == '0))
        else $error("handle set on a non-expiry result");

    // every non-expiry status is a single, final beat
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_OK || status == ST_FULL || status == ST_NONE
                      || status == ST_NO_TIMER) |-> last)
        else $error("single-beat status without last");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(expired_handle) && $stable(last))
        else $error("stalled result beat changed");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .expired_handle(expired_handle), .last(last)
);

// File: tb/deadline_timer_queue_tb.sv
module deadline_timer_queue_tb;
    import dtq_pkg::*;

    localparam int SLOTS = 64;
    localparam int HANDLES = 256;
    localparam logic [47:0] DL_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 1500000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] kind;
    logic [7:0] handle;
    logic [31:0] timeout_ms;
    logic notify;
    logic [47:0] now_ms;
    logic out_valid;
    logic out_stall;
    logic [2:0] status;
    logic [7:0] expired_handle;
    logic last;

    deadline_timer_queue uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .handle(handle), .timeout_ms(timeout_ms),
        .notify(notify), .now_ms(now_ms),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .expired_handle(expired_handle), .last(last)
    );

    // expected result beat
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] hnd;
        logic       last;
    } result_t;

    // shadow timer state
    logic [47:0] tm_deadline [SLOTS];
    logic [7:0]  tm_handle [SLOTS];
    logic        tm_notify [SLOTS];
    logic        tm_deleted [SLOTS];
    logic [5:0]  heap [SLOTS];
    int          heap_size;
    logic        link_ok [HANDLES];
    logic [5:0]  link_slot [HANDLES];
    logic [SLOTS-1:0] slot_free;

    result_t pending_results[$];
    int  fail_count;
    longint cycles;
    logic [47:0] clock_ms;  // monotonic-ish current time for stimulus
    int  stall_mode;

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("[deadline_timer_queue] ERROR");
                $finish;
            end
        end
    end

    function automatic bit sooner(input logic [5:0] a, input logic [5:0] b);
        return tm_deadline[a] < tm_deadline[b] ||
               (tm_deadline[a] == tm_deadline[b] && a < b);
    endfunction

    function automatic void heap_swap(input int i, input int j);
        logic [5:0] t;
        t = heap[i];
        heap[i] = heap[j];
        heap[j] = t;
    endfunction

    // pops the root slot, restores heap order and clears a matching link
    function automatic void take_root();
        logic [5:0] s;
        int p;
        int l;
        int c;
        s = heap[0];
        heap_size--;
        if (heap_size > 0)
        begin
            heap[0] = heap[heap_size];
            p = 0;
            forever
            begin
                l = 2 * p + 1;
                if (l >= heap_size)
                    break;
                c = l;
                if (l + 1 < heap_size && sooner(heap[l + 1], heap[l]))
                    c = l + 1;
                if (!sooner(heap[c], heap[p]))
                    break;
                heap_swap(p, c);
                p = c;
            end
        end
        slot_free[s] = 1'b1;
        if (link_ok[tm_handle[s]] && link_slot[tm_handle[s]] == s)
            link_ok[tm_handle[s]] = 1'b0;
    endfunction

    // computes the result beats of one accepted input beat
    function automatic void predict_timer_op(input logic [1:0] k, input logic [7:0] h,
                                             input logic [31:0] tmo, input logic nt,
                                             input logic [47:0] now);
        int s;
        int p;
        int n;
        logic [48:0] sum;
        logic [5:0] r;
        result_t res;
        if (k == KIND_ADD)
        begin
            if (heap_size >= SLOTS)
            begin
                pending_results.push_back('{ST_FULL, 8'd0, 1'b1});
                return;
            end
            s = 0;
            while (!slot_free[s])
                s++;
            sum = {1'b0, now} + {17'd0, tmo};
            tm_deadline[s] = sum[48] ? DL_MAX : sum[47:0];
            tm_handle[s] = h;
            tm_notify[s] = nt;
            tm_deleted[s] = 1'b0;
            slot_free[s] = 1'b0;
            link_ok[h] = 1'b1;
            link_slot[h] = s[5:0];
            heap[heap_size] = s[5:0];
            p = heap_size;
            heap_size++;
            while (p > 0 && sooner(heap[p], heap[(p - 1) / 2]))
            begin
                heap_swap(p, (p - 1) / 2);
                p = (p - 1) / 2;
            end
            pending_results.push_back('{ST_OK, 8'd0, 1'b1});
        end
        else if (k == KIND_CANCEL)
        begin
            if (link_ok[h])
            begin
                tm_deleted[link_slot[h]] = 1'b1;
                pending_results.push_back('{ST_OK, 8'd0, 1'b1});
            end
            else
                pending_results.push_back('{ST_NO_TIMER, 8'd0, 1'b1});
        end
        else if (k == KIND_EXPIRE)
        begin
            n = 0;
            while (heap_size > 0)
            begin
                r = heap[0];
                if (tm_deleted[r])
                begin
                    take_root();
                    continue;
                end
                if (tm_deadline[r] > now)
                    break;
                take_root();
                if (tm_notify[r] && n < 64)
                begin
                    pending_results.push_back('{ST_EXPIRED, tm_handle[r], 1'b0});
                    n++;
                end
            end
            if (n == 0)
                pending_results.push_back('{ST_NONE, 8'd0, 1'b1});
            else
            begin
                res = pending_results.pop_back();
                res.last = 1'b1;
                pending_results.push_back(res);
            end
        end
    endfunction

    // result checker and receiver stall pattern
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected beat: status=%0d handle=%0d last=%0d",
                           status, expired_handle, last);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (expired_handle !== want.hnd)
                    begin
                        $error("expired_handle: expected %0d actual %0d",
                               want.hnd, expired_handle);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0d actual %0d", want.last, last);
                        fail_count++;
                    end
                end
            end
            // stall pattern: none, light random, heavy random, periodic
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= (cycles % 7) < 3;
            endcase
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 3);
        end
    end

    int burst_left;

    // sends one input beat, holding it until accepted; valid stays up inside a burst
    task automatic send_timer_op(input logic [1:0] k, input logic [7:0] h,
                                 input logic [31:0] tmo, input logic nt,
                                 input logic [47:0] now);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        kind <= k;
        handle <= h;
        timeout_ms <= tmo;
        notify <= nt;
        now_ms <= now;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (k != KIND_UNUSED)
            predict_timer_op(k, h, tmo, nt, now);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic test_directed_edges();
        send_timer_op(KIND_EXPIRE, 8'd0, 32'd0, 1'b0, 48'd0);          // empty sweep
        send_timer_op(KIND_CANCEL, 8'd255, 32'd0, 1'b0, 48'd0);        // no timer
        send_timer_op(KIND_ADD, 8'd0, 32'd0, 1'b1, 48'd100);           // due at once
        send_timer_op(KIND_ADD, 8'd255, 32'hFFFF_FFFF, 1'b1, DL_MAX - 5); // saturates
        send_timer_op(KIND_ADD, 8'd7, 32'd50, 1'b1, 48'd100);
        send_timer_op(KIND_ADD, 8'd7, 32'd60, 1'b1, 48'd100);          // relink
        send_timer_op(KIND_CANCEL, 8'd7, 32'd0, 1'b0, 48'd100);        // cancels newer
        send_timer_op(KIND_CANCEL, 8'd7, 32'd0, 1'b0, 48'd100);        // already deleted
        send_timer_op(KIND_ADD, 8'd9, 32'd50, 1'b0, 48'd100);          // silent, tie
        send_timer_op(KIND_ADD, 8'd10, 32'd50, 1'b1, 48'd100);         // tie, higher slot
        send_timer_op(KIND_UNUSED, 8'hAA, 32'h5555_5555, 1'b1, 48'h5555_5555_5555);
        send_timer_op(KIND_EXPIRE, 8'd0, 32'd0, 1'b0, 48'd149);
        send_timer_op(KIND_EXPIRE, 8'd0, 32'd0, 1'b0, 48'd200);
        send_timer_op(KIND_EXPIRE, 8'd0, 32'd0, 1'b0, DL_MAX - 1);     // not yet due
        send_timer_op(KIND_EXPIRE, 8'd0, 32'd0, 1'b0, DL_MAX);         // saturated fires
        wait_drained();
    endtask

    // fills every slot, checks full, then one sweep flushes all
    task automatic test_queue_full();
        int i;
        for (i = 0; i < SLOTS + 2; i++)
            send_timer_op(KIND_ADD, i[7:0], $urandom_range(0, 40), i[0], 48'd1000);
        send_timer_op(KIND_CANCEL, 8'd3, 32'd0, 1'b0, 48'd1000);
        wait_drained();  // pause until everything is back
        send_timer_op(KIND_EXPIRE, 8'd0, 32'd0, 1'b0, 48'd2000);
        wait_drained();
    endtask

    task automatic test_random_mix();
        int i;
        int pick;
        logic [31:0] tmo;
        logic [7:0] hc;
        clock_ms = 48'd5000;
        for (i = 0; i < 336; i++)
        begin
            pick = $urandom_range(0, 99);
            clock_ms = clock_ms + $urandom_range(0, 20);
            if ($urandom_range(0, 49) == 0)
                clock_ms = 48'({$urandom, $urandom});
            tmo = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 60);
            if (pick < 50)
                send_timer_op(KIND_ADD, 8'($urandom_range(0, 31)), tmo,
                              $urandom_range(0, 3) != 0, clock_ms);
            else if (pick < 68)
            begin
                hc = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                 : 8'($urandom_range(0, 31));
                send_timer_op(KIND_CANCEL, hc, $urandom, 1'($urandom), clock_ms);
            end
            else if (pick < 97)
                send_timer_op(KIND_EXPIRE, 8'($urandom), $urandom, 1'($urandom), clock_ms);
            else
                send_timer_op(KIND_UNUSED, 8'($urandom), $urandom, 1'($urandom),
                              48'({$urandom, $urandom}));
        end
        send_timer_op(KIND_EXPIRE, 8'd0, 32'd0, 1'b0, DL_MAX);
        wait_drained();
    endtask

    initial
    begin
        int i;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        kind = KIND_UNUSED;
        handle = '0;
        timeout_ms = '0;
        notify = 1'b0;
        now_ms = '0;
        fail_count = 0;
        burst_left = 0;
        stall_mode = 0;
        heap_size = 0;
        slot_free = '1;
        for (i = 0; i < HANDLES; i++)
            link_ok[i] = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_queue_full();
        test_random_mix();

        if (fail_count == 0)
            $display("[deadline_timer_queue] OK");
        else
            $display("[deadline_timer_queue] ERROR");
        $finish;
    end
endmodule

// File: sim.f
design/dtq_pkg.sv
design/dtq_ram.sv
design/deadline_timer_queue.sv
design/dtq_checker.sv
tb/deadline_timer_queue_tb.sv
